@@ sv/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted list package
// Shared widths, command codes, cell operation codes and the control bundle
// that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package sli_pkg;

   // Field widths fixed by the interface.
   localparam int DataW     = 32;
   localparam int CmdW      = 2;
   localparam int CountOutW = 6;

   // Default number of cells.
   localparam int DepthDef = 32;

   // Reset value of the purge threshold.
   localparam logic signed [DataW-1:0] ThresholdRst = 32'sd50;

   // Command codes on req_cmd.
   localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
   localparam logic [CmdW-1:0] CMD_PURGE  = 2'd1;
   localparam logic [CmdW-1:0] CMD_DUMP   = 2'd2;

   // Operation codes that every cell executes in the same cycle.
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_SHIFT  = 2'd2;
   localparam logic [1:0] OP_ROTATE = 2'd3;

   // Control broadcast from the sequencer to the cells.
   typedef struct packed {
      logic [1:0]              op;
      logic signed [DataW-1:0] value;
      logic signed [DataW-1:0] head;
   } cell_ctrl_type;

endpackage

@@ sv/sorted_list_insert_and_purge_core.sv @@
// ----------------------------------------------------------------------------
// Sorted list insert and purge core
// Holds up to DEPTH signed values in ascending order in a chain of cells.
//
// Usage: raise start with req_cmd and req_value while busy is low; the item
// is taken at that clock edge. Results appear on the rsp_ ports for one
// cycle each, marked by rsp_valid, and cannot be held off by the receiver.
// Insert: the chain compares and shifts in the accept cycle; its single
// status result follows in the next cycle and a new item is taken at once.
// Purge: removes one leading entry per cycle while the head is at or below
// the threshold and the list is not empty, busy meanwhile; then one result.
// Dump: rotates the chain once per entry, giving one result per entry, one
// per cycle (one result when empty); busy until the last entry is given.
// The rate is set by the single-step shift of the chain for purge and the
// one-entry-per-cycle rotation for dump. Command 3 is taken and ignored.
// The threshold is written through csr_we/csr_wdata; the user is bound to
// write it only while idle, and the block has no check of its own. Reset
// clears the count to empty and the threshold to 50; there is no clearing pass.
// ----------------------------------------------------------------------------
module sorted_list_insert_and_purge_core
   import sli_pkg::*;
#(
   parameter int DEPTH = DepthDef
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CmdW-1:0]         req_cmd,
   input  logic signed [DataW-1:0] req_value,
   output logic                    rsp_valid,
   output logic signed [DataW-1:0] rsp_entry,
   output logic                    rsp_entry_valid,
   output logic                    rsp_last,
   output logic [CountOutW-1:0]    rsp_count,
   output logic                    rsp_status,
   input  logic                    csr_we,
   input  logic signed [DataW-1:0] csr_wdata
);

   localparam int CW = $clog2(DEPTH+1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PURGE = 2'd1;
   localparam logic [1:0] ST_DUMP  = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic signed [DataW-1:0] threshold_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DataW-1:0] rsp_entry_ff, rsp_entry_in;
   logic                    rsp_entry_valid_ff, rsp_entry_valid_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [CountOutW-1:0]    rsp_count_ff, rsp_count_in;
   logic                    rsp_status_ff, rsp_status_in;

   cell_ctrl_type           ctrl;
   logic signed [DataW-1:0] cell_entry [DEPTH];
   logic                    cell_keep  [DEPTH];
   logic signed [DataW-1:0] head;
   logic                    at_tail;
   logic [6:0]              count_wide;

   assign head    = cell_entry[0];
   assign at_tail = (idx_ff + CW'(1)) == count_ff;
   assign busy    = state_ff != ST_IDLE;

   // Chain of cells; each sees its left and right neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DataW-1:0] prev_entry;
      logic                    prev_keep;
      logic signed [DataW-1:0] next_entry;

      if (i == 0) begin : g_first
         assign prev_entry = req_value;
         assign prev_keep  = 1'b1;
      end else begin : g_mid
         assign prev_entry = cell_entry[i-1];
         assign prev_keep  = cell_keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_entry = head;
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      sli_cell #(
         .DEPTH (DEPTH),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .count      (count_ff),
         .ctrl       (ctrl),
         .prev_entry (prev_entry),
         .prev_keep  (prev_keep),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .keep       (cell_keep[i])
      );
   end

   // Sequencer: decodes commands, steps purge and dump, builds results.
   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      idx_in             = idx_ff;
      ctrl.op            = OP_HOLD;
      ctrl.value         = req_value;
      ctrl.head          = head;
      rsp_valid_in       = 1'b0;
      rsp_entry_in       = '0;
      rsp_entry_valid_in = 1'b0;
      rsp_last_in        = 1'b0;
      rsp_status_in      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  CMD_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        ctrl.op  = OP_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_PURGE: begin
                     state_in = ST_PURGE;
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_last_in  = 1'b1;
                     end else begin
                        state_in = ST_DUMP;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_PURGE: begin
            if ((count_ff != '0) && (head <= threshold_ff)) begin
               ctrl.op  = OP_SHIFT;
               count_in = count_ff - CW'(1);
            end else begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DUMP: begin
            ctrl.op            = OP_ROTATE;
            rsp_valid_in       = 1'b1;
            rsp_entry_in       = head;
            rsp_entry_valid_in = 1'b1;
            rsp_last_in        = at_tail;
            idx_in             = idx_ff + CW'(1);
            if (at_tail) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The reported count wraps at 64.
   assign count_wide   = 7'(count_in);
   assign rsp_count_in = count_wide[CountOutW-1:0];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= ThresholdRst;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            threshold_ff <= csr_wdata;
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      rsp_entry_ff       <= rsp_entry_in;
      rsp_entry_valid_ff <= rsp_entry_valid_in;
      rsp_last_ff        <= rsp_last_in;
      rsp_count_ff       <= rsp_count_in;
      rsp_status_ff      <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry       = rsp_entry_ff;
   assign rsp_entry_valid = rsp_entry_valid_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   // The fill count never exceeds the number of cells.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   // A dropped insert is reported only when the store is full.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (count_ff == CW'(DEPTH)))
      else $error("insert dropped while store not full");

   // Entry results come only from dump steps.
   a_entry_from_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_valid) |-> $past(state_ff == ST_DUMP))
      else $error("entry result outside dump");

   // A purge step never grows the list.
   a_purge_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PURGE) |=> (count_ff <= $past(count_ff)))
      else $error("purge grew the list");

endmodule

@@ sv/sli_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted list cell
// One position of the sorted chain. It holds one entry and, on each cycle,
// keeps it, takes the new value, a neighbor's entry or the head entry.
// ----------------------------------------------------------------------------
module sli_cell
   import sli_pkg::*;
#(
   parameter int DEPTH = DepthDef,
   parameter int IDX   = 0
) (
   input  logic                           clock,
   input  logic [$clog2(DEPTH+1)-1:0]     count,
   input  cell_ctrl_type                  ctrl,
   input  logic signed [DataW-1:0]        prev_entry,
   input  logic                           prev_keep,
   input  logic signed [DataW-1:0]        next_entry,
   output logic signed [DataW-1:0]        entry,
   output logic                           keep
);

   localparam int CW = $clog2(DEPTH+1);

   logic signed [DataW-1:0] entry_ff;
   logic signed [DataW-1:0] entry_in;
   logic                    occupied;
   logic                    is_tail;

   // Position flags against the current fill count.
   assign occupied = CW'(IDX) < count;
   assign is_tail  = CW'(IDX + 1) == count;

   // An occupied entry strictly below the new value stays where it is.
   assign keep = occupied && (entry_ff < ctrl.value);

   // Next entry for the broadcast operation.
   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         OP_INSERT: begin
            if (!keep) begin
               entry_in = prev_keep ? ctrl.value : prev_entry;
            end
         end
         OP_SHIFT: begin
            entry_in = next_entry;
         end
         OP_ROTATE: begin
            if (is_tail) begin
               entry_in = ctrl.head;
            end else if (occupied) begin
               entry_in = next_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Sorted list insert and purge testbench
// Drives insert, purge, dump and unused commands through the start/busy port.
// A queue model of the sorted list predicts every status and dump result, and
// each strobed result is checked against the oldest prediction. The purge
// threshold is rewritten between phases, the extremes among the settings.
// ----------------------------------------------------------------------------
module testbench;
   import sli_pkg::*;

   localparam int Depth = DepthDef;
   localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [DataW-1:0] ValueMin = 32'sh8000_0000;
   localparam logic signed [DataW-1:0] ValueMax = 32'sh7fff_ffff;
   localparam int MaxReports = 10;

   // One item waiting to be sent to the list.
   typedef struct {
      logic [CmdW-1:0]         cmd;
      logic signed [DataW-1:0] value;
      bit                      drain_first;
   } list_op_type;

   // One result as the list reports it.
   typedef struct packed {
      logic signed [DataW-1:0] entry;
      logic                    entry_valid;
      logic                    last;
      logic [CountOutW-1:0]    count;
      logic                    status;
   } list_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [CmdW-1:0]         req_cmd = CMD_INSERT;
   logic signed [DataW-1:0] req_value = '0;
   logic                    rsp_valid;
   logic signed [DataW-1:0] rsp_entry;
   logic                    rsp_entry_valid;
   logic                    rsp_last;
   logic [CountOutW-1:0]    rsp_count;
   logic                    rsp_status;
   logic                    csr_we = 1'b0;
   logic signed [DataW-1:0] csr_wdata = '0;

   list_op_type             pending_ops[$];
   list_result_type         expected_results[$];
   logic signed [DataW-1:0] sorted_model[$];
   logic signed [DataW-1:0] threshold_model = ThresholdRst;
   logic                    item_taken = 1'b0;
   int                      sender_gap_pct = 7;
   int                      mismatch_count = 0;

   sorted_list_insert_and_purge_core #(
      .DEPTH(Depth)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_entry      (rsp_entry),
      .rsp_entry_valid(rsp_entry_valid),
      .rsp_last       (rsp_last),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   // Clock with a period of 12.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Update the list model for one accepted item and queue its results.
   task automatic predict_list_op(input logic [CmdW-1:0] cmd,
                                  input logic signed [DataW-1:0] value);
      int pos;
      list_result_type res;
      res = '0;
      res.last = 1'b1;
      case (cmd)
         CMD_INSERT: begin
            if (sorted_model.size() >= Depth) begin
               res.status = 1'b1;
            end else begin
               // A new value goes in front of any entries equal to it.
               pos = 0;
               while (pos < sorted_model.size() && sorted_model[pos] < value) pos++;
               sorted_model.insert(pos, value);
            end
            res.count = CountOutW'(sorted_model.size());
            expected_results.push_back(res);
         end
         CMD_PURGE: begin
            while (sorted_model.size() != 0 && sorted_model[0] <= threshold_model)
               void'(sorted_model.pop_front());
            res.count = CountOutW'(sorted_model.size());
            expected_results.push_back(res);
         end
         CMD_DUMP: begin
            if (sorted_model.size() == 0) begin
               expected_results.push_back(res);
            end else begin
               for (int i = 0; i < sorted_model.size(); i++) begin
                  res.entry       = sorted_model[i];
                  res.entry_valid = 1'b1;
                  res.last        = (i == sorted_model.size() - 1);
                  res.count       = CountOutW'(sorted_model.size());
                  expected_results.push_back(res);
               end
            end
         end
         default: begin
            // The unused command is taken and gives no result.
         end
      endcase
   endtask

   // Pick a value: mostly close to the threshold, with extremes and wide values.
   function automatic logic signed [DataW-1:0] pick_value(
      input logic signed [DataW-1:0] thr);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 5))
            0: return ValueMin;
            1: return ValueMax;
            2: return ValueMin + 1;
            3: return ValueMax - 1;
            4: return '0;
            default: return '1;
         endcase
      end else if (r <= 5) begin
         return thr + DataW'($urandom_range(0, 40)) - 32'sd20;
      end
      return $urandom;
   endfunction

   task automatic push_op(input logic [CmdW-1:0] cmd,
                          input logic signed [DataW-1:0] value,
                          input bit drain_first = 1'b0);
      list_op_type op;
      op.cmd         = cmd;
      op.value       = value;
      op.drain_first = drain_first;
      pending_ops.push_back(op);
   endtask

   // Random command mix, optionally led by a run that overfills the list.
   task automatic queue_random_ops(input int n, input bit overfill,
                                   input logic signed [DataW-1:0] thr);
      int unsigned r;
      bit drain;
      if (overfill) begin
         for (int i = 0; i < Depth + 2; i++) push_op(CMD_INSERT, pick_value(thr));
         push_op(CMD_DUMP, '0);
         push_op(CMD_PURGE, '0);
         push_op(CMD_DUMP, '0);
      end
      for (int i = 0; i < n; i++) begin
         r     = $urandom_range(0, 99);
         drain = ($urandom_range(0, 29) == 0);
         if (r < 52) push_op(CMD_INSERT, pick_value(thr), drain);
         else if (r < 67) push_op(CMD_PURGE, $urandom, drain);
         else if (r < 92) push_op(CMD_DUMP, $urandom, drain);
         else push_op(CMD_UNUSED, $urandom, drain);
      end
   endtask

   // Wait until every item is sent and every result is in, then let the
   // block settle.
   task automatic drain_list();
      while (pending_ops.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [DataW-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Driver: holds an item until it is taken, then presents the next one or
   // idles.
   always @(negedge clock) begin
      if (!reset && (!start || item_taken)) begin
         if (item_taken) void'(pending_ops.pop_front());
         if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct &&
             !(pending_ops[0].drain_first && expected_results.size() != 0)) begin
            start     <= 1'b1;
            req_cmd   <= pending_ops[0].cmd;
            req_value <= pending_ops[0].value;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks each strobed result, then predicts for the item taken
   // at this edge.
   always @(posedge clock) begin : watch_results
      list_result_type got;
      list_result_type want;
      if (reset) begin
         item_taken      <= 1'b0;
         threshold_model = ThresholdRst;
         sorted_model.delete();
         expected_results.delete();
      end else begin
         item_taken <= start && !busy;
         if (csr_we) threshold_model = csr_wdata;
         if (rsp_valid) begin
            got = {rsp_entry, rsp_entry_valid, rsp_last, rsp_count, rsp_status};
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MaxReports)
                  $display("unexpected result at %0t: entry %0d valid %0b last %0b %s",
                           $time, got.entry, got.entry_valid, got.last,
                           $sformatf("count %0d status %0b", got.count, got.status));
            end else begin
               want = expected_results.pop_front();
               if (got.entry != want.entry || got.entry_valid != want.entry_valid ||
                   got.last != want.last || got.count != want.count ||
                   got.status != want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= MaxReports) begin
                     $display("mismatch at %0t: expected entry %0d valid %0b last %0b %s",
                              $time, want.entry, want.entry_valid, want.last,
                              $sformatf("count %0d status %0b", want.count, want.status));
                     $display("             got      entry %0d valid %0b last %0b %s",
                              got.entry, got.entry_valid, got.last,
                              $sformatf("count %0d status %0b", got.count, got.status));
                  end
               end
            end
         end
         if (start && !busy) predict_list_op(req_cmd, req_value);
      end
   end

   // Stimulus phases: each sets a threshold and a sender gap rate.
   initial begin : run_phases
      logic signed [DataW-1:0] thr;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      for (int seg = 0; seg < 6; seg++) begin
         drain_list();
         case (seg)
            0: thr = ThresholdRst;
            1: thr = DataW'($urandom_range(0, 2000)) - 32'sd1000;
            2: thr = ValueMax;
            3: thr = ValueMin;
            4: thr = $urandom;
            default: thr = '0;
         endcase
         if (seg > 0) write_threshold(thr);
         sender_gap_pct = (seg < 2) ? 7 : (seg < 4) ? 73 : 0;
         if (seg == 0) begin
            // Empty list cases, extremes, equal values and an ordinary purge.
            push_op(CMD_DUMP, '0);
            push_op(CMD_PURGE, '0);
            push_op(CMD_INSERT, 32'sd50);
            push_op(CMD_INSERT, 32'sd50);
            push_op(CMD_INSERT, ValueMax);
            push_op(CMD_INSERT, ValueMin);
            push_op(CMD_INSERT, '0);
            push_op(CMD_INSERT, '1);
            push_op(CMD_INSERT, 32'sd51);
            push_op(CMD_INSERT, 32'sd49);
            push_op(CMD_INSERT, 32'sh5555_5555);
            push_op(CMD_INSERT, 32'shaaaa_aaaa);
            push_op(CMD_UNUSED, 32'sd123);
            // Hold the dump back until all inserts have reported.
            push_op(CMD_DUMP, '1, 1'b1);
            push_op(CMD_PURGE, '0);
            push_op(CMD_DUMP, '0);
            push_op(CMD_PURGE, '1);
            push_op(CMD_INSERT, 32'sd50);
            push_op(CMD_DUMP, '0);
         end
         queue_random_ops(25, seg == 2 || seg == 4, thr);
      end
      drain_list();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #6000000;
      $display("FAILURE");
      $finish;
   end

endmodule

@@ sorted_list_insert_and_purge_core.f @@
sv/sli_pkg.sv
sv/sli_cell.sv
sv/sorted_list_insert_and_purge_core.sv
dv/testbench.sv
